/* hw/rtl/lal_pkg.sv */
// ----------------------------------------------------------------------------
// lal_pkg
// Shared types and constants of the line-aware character lexer: token kinds,
// scan modes and the result word that travels from the scanner to the queue.
// ----------------------------------------------------------------------------
package lal_pkg;

  localparam int NUMBER_BITS_DEF = 31;
  localparam int OUT_NUM_W       = 31;
  localparam int Q_DEPTH         = 4;
  localparam int Q_AW            = $clog2(Q_DEPTH);

  typedef enum logic [3:0] {
    KIND_END     = 4'd0,
    KIND_EOL     = 4'd1,
    KIND_INDENT  = 4'd2,
    KIND_INTEGER = 4'd3,
    KIND_NAME    = 4'd4,
    KIND_STRING  = 4'd5,
    KIND_SYMBOL  = 4'd6,
    KIND_RELOP   = 4'd7,
    KIND_ERROR   = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_NAME    = 3'd1,
    MODE_STRING  = 3'd2,
    MODE_INDENT  = 3'd3,
    MODE_INTEGER = 3'd4,
    MODE_RELOP   = 3'd5
  } mode_t;

  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            piece_char;
    logic                  piece_valid;
    logic [OUT_NUM_W-1:0]  number;
    logic                  number_saturated;
    logic                  last_piece;
    logic                  bool_op;
  } res_t;

  function automatic res_t mk_res(kind_t k, logic [7:0] ch, logic pv, logic last);
    res_t r;
    r                  = '0;
    r.kind             = k;
    r.piece_char       = ch;
    r.piece_valid      = pv;
    r.last_piece       = last;
    return r;
  endfunction

endpackage

/* hw/rtl/line_aware_char_lexer_unit.sv */
// ----------------------------------------------------------------------------
// line_aware_char_lexer_unit
// Streaming lexer: one character or end-of-input marker per word, typed
// token pieces out, one per word on the result side.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle while the result queue has room.
// Path: a word goes through the input register, then the step into the
//   result queue, whose head drives the output; name, string and
//   indent pieces trail by one character because the last piece is held.
// A word that causes two results pushes both into the queue at once; the
//   queue absorbs them. Synchronous active-low reset returns to line start, idle.
module line_aware_char_lexer_unit #(
  parameter int NUMBER_BITS = lal_pkg::NUMBER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic [7:0]                  in_char,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  out_kind,
  output logic [7:0]                  out_piece_char,
  output logic                        out_piece_valid,
  output logic [lal_pkg::OUT_NUM_W-1:0] out_number,
  output logic                        out_number_saturated,
  output logic                        out_last_piece,
  output logic                        out_bool_op
);
  import lal_pkg::*;

  // input register
  logic       iv_r, iv_nxt;
  logic       req_r;
  logic [7:0] chr_r;

  logic       room2, adv, take, pop;
  logic [1:0] res_v;
  res_t [1:0] res;
  res_t       rd_word;

  // advance the held word only when the queue can take two results
  assign adv      = iv_r && room2;
  assign in_stall = iv_r && !room2;
  assign take     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_comb begin
    iv_nxt = iv_r;
    if (take)     iv_nxt = 1'b1;
    else if (adv) iv_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else begin
      iv_r <= iv_nxt;
    end
  end

  // payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_req_type;
      chr_r <= in_char;
    end
  end

  lal_step #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (adv),
    .req_type (req_r),
    .ch       (chr_r),
    .res_v    (res_v),
    .res      (res)
  );

  lal_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_v   (res_v),
    .push_w   (res),
    .pop      (pop),
    .rd_valid (out_valid),
    .rd_word  (rd_word),
    .room2    (room2)
  );

  // drive result fields from the queue head
  assign out_kind             = rd_word.kind;
  assign out_piece_char       = rd_word.piece_char;
  assign out_piece_valid      = rd_word.piece_valid;
  assign out_number           = rd_word.number;
  assign out_number_saturated = rd_word.number_saturated;
  assign out_last_piece       = rd_word.last_piece;
  assign out_bool_op          = rd_word.bool_op;

endmodule

/* hw/rtl/lal_step.sv */
// ----------------------------------------------------------------------------
// lal_step
// Scanner state and the single-pass step: one character in, up to two
// result words out, packed so that the first valid word sits in slot 0.
// ----------------------------------------------------------------------------
module lal_step #(
  parameter int NUMBER_BITS = lal_pkg::NUMBER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic                req_type,
  input  logic [7:0]          ch,
  output logic [1:0]          res_v,
  output lal_pkg::res_t [1:0] res
);
  import lal_pkg::*;

  localparam logic [3:0] KW_DEAD = 4'd15;
  localparam logic [3:0] KW_AND  = 4'd3;
  localparam logic [3:0] KW_OR   = 4'd5;
  localparam logic [3:0] KW_NOT  = 4'd8;

  mode_t                  mode_r, mode_nxt;
  logic [7:0]             held_r, held_nxt;
  logic                   hv_r, hv_nxt;
  logic [NUMBER_BITS-1:0] acc_r, acc_nxt;
  logic                   sat_r, sat_nxt;
  logic [3:0]             kw_r, kw_nxt;
  logic                   als_r, als_nxt;
  logic                   stop_r, stop_nxt;

  logic                   c_space, c_lf, c_digit, c_alpha, c_relop, c_sym, c_quote;
  logic [NUMBER_BITS+3:0] acc_ext, prod, maxv;
  logic [OUT_NUM_W+NUMBER_BITS-1:0] acc_wide;
  logic                   fin_v, idl_v, fall;
  res_t                   fin_r, idl_r, main_r;
  logic                   main_v;

  function automatic logic [3:0] kw_next(logic [3:0] s, logic [7:0] c);
    logic [3:0] n;
    n = KW_DEAD;
    case (s)
      4'd0: begin
        if (c == "a") n = 4'd1;
        else if (c == "o") n = 4'd4;
        else if (c == "n") n = 4'd6;
      end
      4'd1: if (c == "n") n = 4'd2;
      4'd2: if (c == "d") n = 4'd3;
      4'd4: if (c == "r") n = 4'd5;
      4'd6: if (c == "o") n = 4'd7;
      4'd7: if (c == "t") n = 4'd8;
      default: n = KW_DEAD;
    endcase
    return n;
  endfunction

  // character classes
  assign c_lf    = (ch == 8'h0a);
  assign c_space = (ch == 8'h20) || (ch >= 8'd9 && ch <= 8'd13);
  assign c_digit = (ch >= "0") && (ch <= "9");
  assign c_alpha = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  assign c_relop = (ch == "=") || (ch == ">") || (ch == "<") || (ch == "!");
  assign c_quote = (ch == 8'h22);
  assign c_sym   = ch inside {";", ",", ":", ".", "+", "-", "*", "/", "%",
                              "(", ")", "{", "}", "[", "]"};

  // accumulate one digit: acc*10 + d, clamp past the width
  assign acc_ext  = {4'b0, acc_r};
  assign prod     = (acc_ext << 3) + (acc_ext << 1) + {{NUMBER_BITS{1'b0}}, ch[3:0]};
  assign maxv     = {4'b0, {NUMBER_BITS{1'b1}}};
  assign acc_wide = {{OUT_NUM_W{1'b0}}, acc_r};

  // final word of the pending token
  always_comb begin
    fin_v = 1'b1;
    fin_r = '0;
    case (mode_r)
      MODE_NAME: begin
        fin_r         = mk_res(KIND_NAME, held_r, 1'b1, 1'b1);
        fin_r.bool_op = (kw_r == KW_AND) || (kw_r == KW_OR) || (kw_r == KW_NOT);
      end
      MODE_STRING:  fin_r = mk_res(KIND_STRING, hv_r ? held_r : 8'd0, hv_r, 1'b1);
      MODE_INDENT:  fin_r = mk_res(KIND_INDENT, held_r, 1'b1, 1'b1);
      MODE_INTEGER: begin
        fin_r                  = mk_res(KIND_INTEGER, 8'd0, 1'b0, 1'b1);
        fin_r.number           = acc_wide[OUT_NUM_W-1:0];
        fin_r.number_saturated = sat_r;
      end
      MODE_RELOP:   fin_r = mk_res(KIND_SYMBOL, held_r, 1'b1, 1'b1);
      default:      fin_v = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    held_nxt = held_r;
    hv_nxt   = hv_r;
    acc_nxt  = acc_r;
    sat_nxt  = sat_r;
    kw_nxt   = kw_r;
    als_nxt  = als_r;
    stop_nxt = stop_r;
    main_v   = 1'b0;
    main_r   = '0;
    idl_v    = 1'b0;
    idl_r    = '0;
    fall     = 1'b0;
    res_v    = 2'b00;
    res      = '0;

    if (go && !stop_r) begin
      if (req_type) begin
        // end of input: close the pending token, then the end word; back to reset
        res[0]   = fin_v ? fin_r : mk_res(KIND_END, 8'd0, 1'b0, 1'b1);
        res[1]   = mk_res(KIND_END, 8'd0, 1'b0, 1'b1);
        res_v    = fin_v ? 2'b11 : 2'b01;
        mode_nxt = MODE_IDLE;
        held_nxt = '0;
        hv_nxt   = 1'b0;
        acc_nxt  = '0;
        sat_nxt  = 1'b0;
        kw_nxt   = '0;
        als_nxt  = 1'b1;
      end else begin
        case (mode_r)
          MODE_NAME: begin
            if (c_alpha || c_digit) begin
              main_v   = 1'b1;
              main_r   = mk_res(KIND_NAME, held_r, 1'b1, 1'b0);
              held_nxt = ch;
              kw_nxt   = kw_next(kw_r, ch);
            end else begin
              fall = 1'b1;
            end
          end
          MODE_STRING: begin
            if (c_quote) begin
              main_v   = 1'b1;
              main_r   = fin_r;
              mode_nxt = MODE_IDLE;
              hv_nxt   = 1'b0;
            end else begin
              main_v   = hv_r;
              main_r   = mk_res(KIND_STRING, held_r, 1'b1, 1'b0);
              held_nxt = ch;
              hv_nxt   = 1'b1;
            end
          end
          MODE_INDENT: begin
            if (c_space && !c_lf) begin
              main_v   = 1'b1;
              main_r   = mk_res(KIND_INDENT, held_r, 1'b1, 1'b0);
              held_nxt = ch;
            end else begin
              fall = 1'b1;
            end
          end
          MODE_INTEGER: begin
            if (c_digit) begin
              if (sat_r || (prod > maxv)) begin
                acc_nxt = {NUMBER_BITS{1'b1}};
                sat_nxt = 1'b1;
              end else begin
                acc_nxt = prod[NUMBER_BITS-1:0];
              end
            end else begin
              fall = 1'b1;
            end
          end
          MODE_RELOP: begin
            if (ch == "=") begin
              main_v   = 1'b1;
              main_r   = mk_res(KIND_RELOP, held_r, 1'b1, 1'b1);
              mode_nxt = MODE_IDLE;
            end else begin
              fall = 1'b1;
            end
          end
          default: fall = 1'b1;
        endcase

        if (fall) begin
          // close whatever was pending, then start fresh on this character
          main_v   = fin_v;
          main_r   = fin_r;
          if (fin_v) hv_nxt = 1'b0;
          mode_nxt = MODE_IDLE;
          if (c_space && !c_lf) begin
            if (als_r) begin
              mode_nxt = MODE_INDENT;
              held_nxt = ch;
              hv_nxt   = 1'b1;
              als_nxt  = 1'b0;
            end
          end else if (c_lf) begin
            idl_v   = 1'b1;
            idl_r   = mk_res(KIND_EOL, 8'd0, 1'b0, 1'b1);
            als_nxt = 1'b1;
          end else begin
            als_nxt = 1'b0;
            if (c_digit) begin
              mode_nxt = MODE_INTEGER;
              acc_nxt  = {{(NUMBER_BITS-4){1'b0}}, ch[3:0]};
              sat_nxt  = 1'b0;
            end else if (c_relop) begin
              mode_nxt = MODE_RELOP;
              held_nxt = ch;
              hv_nxt   = 1'b1;
            end else if (c_sym) begin
              idl_v = 1'b1;
              idl_r = mk_res(KIND_SYMBOL, ch, 1'b1, 1'b1);
            end else if (c_alpha) begin
              mode_nxt = MODE_NAME;
              held_nxt = ch;
              hv_nxt   = 1'b1;
              kw_nxt   = kw_next(4'd0, ch);
            end else if (c_quote) begin
              mode_nxt = MODE_STRING;
              hv_nxt   = 1'b0;
            end else begin
              idl_v    = 1'b1;
              idl_r    = mk_res(KIND_ERROR, ch, 1'b1, 1'b1);
              stop_nxt = 1'b1;
            end
          end
        end

        // pack: first valid word goes to slot 0
        if (main_v) begin
          res[0] = main_r;
          res[1] = idl_r;
          res_v  = {idl_v, 1'b1};
        end else begin
          res[0] = idl_r;
          res_v  = {1'b0, idl_v};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      held_r <= '0;
      hv_r   <= 1'b0;
      acc_r  <= '0;
      sat_r  <= 1'b0;
      kw_r   <= '0;
      als_r  <= 1'b1;
      stop_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      hv_r   <= hv_nxt;
      acc_r  <= acc_nxt;
      sat_r  <= sat_nxt;
      kw_r   <= kw_nxt;
      als_r  <= als_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

/* hw/rtl/lal_outq.sv */
// ----------------------------------------------------------------------------
// lal_outq
// Small result queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
module lal_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_v,
  input  lal_pkg::res_t [1:0] push_w,
  input  logic                pop,
  output logic                rd_valid,
  output lal_pkg::res_t       rd_word,
  output logic                room2
);
  import lal_pkg::*;

  res_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic [Q_AW-1:0] wr_p1;

  assign rd_valid = (cnt_r != '0);
  assign rd_word  = mem[rd_r];
  assign room2    = (cnt_r <= (Q_AW+1)'(Q_DEPTH - 2));
  assign wr_p1    = wr_r + 1'b1;

  always_comb begin
    wr_nxt  = wr_r + {{(Q_AW-1){1'b0}}, push_v[0]} + {{(Q_AW-1){1'b0}}, push_v[1]};
    rd_nxt  = rd_r + {{(Q_AW-1){1'b0}}, pop};
    cnt_nxt = cnt_r + {{Q_AW{1'b0}}, push_v[0]} + {{Q_AW{1'b0}}, push_v[1]}
              - {{Q_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push_v[0]) mem[wr_r] <= push_w[0];
    if (push_v[1]) mem[wr_p1] <= push_w[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for line_aware_char_lexer_unit. A directed opening and
// a long run of random source lines go in through the input channel; a
// predictor of the lexer works out every token piece, and each piece taken
// from the result channel is compared field by field. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lal_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 9;
  localparam int NUM_BITS     = NUMBER_BITS_DEF;
  localparam int ITEM_TARGET  = 1650;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_SPACING = 800;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 300000;

  // Character bytes the lexer treats specially.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // Keyword tracker: how much of and / or / not the current name matches.
  localparam logic [3:0] KW_NONE = 4'd0;
  localparam logic [3:0] KW_A    = 4'd1;
  localparam logic [3:0] KW_AN   = 4'd2;
  localparam logic [3:0] KW_AND  = 4'd3;
  localparam logic [3:0] KW_O    = 4'd4;
  localparam logic [3:0] KW_OR   = 4'd5;
  localparam logic [3:0] KW_N    = 4'd6;
  localparam logic [3:0] KW_NO   = 4'd7;
  localparam logic [3:0] KW_NOT  = 4'd8;
  localparam logic [3:0] KW_DEAD = 4'd15;

  // Receiver stall styles.
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_BEAT  = 3;

  // --------------------------------------------------------------------------
  // Token predictor and store of expected token pieces.
  // --------------------------------------------------------------------------
  class lexer_scoreboard;
    res_t            expected_q[$];
    int              errors;
    mode_t           mode;
    logic [7:0]      held_char;
    bit              held_valid;
    longint unsigned accum;
    bit              sat;
    logic [3:0]      kw;
    bit              line_start;
    bit              stopped;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode       = MODE_IDLE;
      held_char  = 8'h00;
      held_valid = 1'b0;
      accum      = 0;
      sat        = 1'b0;
      kw         = KW_NONE;
      line_start = 1'b1;
      stopped    = 1'b0;
    endfunction

    function bit is_ws(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_relop_char(logic [7:0] c);
      return c == CH_EQ || c == ">" || c == "<" || c == "!";
    endfunction

    function bit is_symbol(logic [7:0] c);
      case (c)
        ";", ",", ":", ".", "+", "-", "*", "/", "%",
        "(", ")", "{", "}", "[", "]": return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit is_known(logic [7:0] c);
      return is_ws(c) || is_digit(c) || is_letter(c) || is_relop_char(c) ||
             is_symbol(c) || c == CH_QUOTE;
    endfunction

    function logic [3:0] kw_step(logic [3:0] s, logic [7:0] c);
      case (s)
        KW_NONE: return c == "a" ? KW_A : c == "o" ? KW_O : c == "n" ? KW_N : KW_DEAD;
        KW_A:    return c == "n" ? KW_AN : KW_DEAD;
        KW_AN:   return c == "d" ? KW_AND : KW_DEAD;
        KW_O:    return c == "r" ? KW_OR : KW_DEAD;
        KW_N:    return c == "o" ? KW_NO : KW_DEAD;
        KW_NO:   return c == "t" ? KW_NOT : KW_DEAD;
        default: return KW_DEAD;
      endcase
    endfunction

    function void add_piece(kind_t k, logic [7:0] ch, bit pv, bit last, bit bop);
      res_t r;
      r             = '0;
      r.kind        = k;
      r.piece_char  = ch;
      r.piece_valid = pv;
      r.last_piece  = last;
      r.bool_op     = bop;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void add_integer();
      res_t r;
      r                  = '0;
      r.kind             = KIND_INTEGER;
      r.number           = accum[OUT_NUM_W-1:0];
      r.number_saturated = sat;
      r.last_piece       = 1'b1;
      expected_q.insert(expected_q.size(), r);
    endfunction

    // Final piece of whatever token is pending.
    function void close_token();
      case (mode)
        MODE_NAME:    add_piece(KIND_NAME, held_char, 1'b1, 1'b1,
                                kw == KW_AND || kw == KW_OR || kw == KW_NOT);
        MODE_STRING:  add_piece(KIND_STRING, held_valid ? held_char : 8'h00,
                                held_valid, 1'b1, 1'b0);
        MODE_INDENT:  add_piece(KIND_INDENT, held_char, 1'b1, 1'b1, 1'b0);
        MODE_INTEGER: add_integer();
        MODE_RELOP:   add_piece(KIND_SYMBOL, held_char, 1'b1, 1'b1, 1'b0);
        default: ;
      endcase
    endfunction

    // Character seen with no token pending.
    function void open_token(logic [7:0] c);
      mode = MODE_IDLE;
      if (is_ws(c) && c != CH_LF) begin
        if (line_start) begin
          mode       = MODE_INDENT;
          held_char  = c;
          held_valid = 1'b1;
          line_start = 1'b0;
        end
      end else if (c == CH_LF) begin
        add_piece(KIND_EOL, 8'h00, 1'b0, 1'b1, 1'b0);
        line_start = 1'b1;
      end else begin
        line_start = 1'b0;
        if (is_digit(c)) begin
          mode  = MODE_INTEGER;
          accum = c - CH_ZERO;
          sat   = 1'b0;
        end else if (is_relop_char(c)) begin
          mode       = MODE_RELOP;
          held_char  = c;
          held_valid = 1'b1;
        end else if (is_symbol(c)) begin
          add_piece(KIND_SYMBOL, c, 1'b1, 1'b1, 1'b0);
        end else if (is_letter(c)) begin
          mode       = MODE_NAME;
          held_char  = c;
          held_valid = 1'b1;
          kw         = kw_step(KW_NONE, c);
        end else if (c == CH_QUOTE) begin
          mode       = MODE_STRING;
          held_valid = 1'b0;
        end else begin
          add_piece(KIND_ERROR, c, 1'b1, 1'b1, 1'b0);
          stopped = 1'b1;
        end
      end
    endfunction

    function void note_word(bit eoi, logic [7:0] c);
      longint unsigned max_val;
      longint unsigned digit;
      if (stopped) return;
      if (eoi) begin
        close_token();
        add_piece(KIND_END, 8'h00, 1'b0, 1'b1, 1'b0);
        clear_state();
        return;
      end
      case (mode)
        MODE_NAME: if (is_letter(c) || is_digit(c)) begin
          add_piece(KIND_NAME, held_char, 1'b1, 1'b0, 1'b0);
          held_char = c;
          kw        = kw_step(kw, c);
          return;
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            close_token();
            mode       = MODE_IDLE;
            held_valid = 1'b0;
            return;
          end
          if (held_valid) add_piece(KIND_STRING, held_char, 1'b1, 1'b0, 1'b0);
          held_char  = c;
          held_valid = 1'b1;
          return;
        end
        MODE_INDENT: if (is_ws(c) && c != CH_LF) begin
          add_piece(KIND_INDENT, held_char, 1'b1, 1'b0, 1'b0);
          held_char = c;
          return;
        end
        MODE_INTEGER: if (is_digit(c)) begin
          max_val = (64'd1 << NUM_BITS) - 1;
          digit   = c - CH_ZERO;
          if (sat || accum > (max_val - digit) / 10) begin
            accum = max_val;
            sat   = 1'b1;
          end else begin
            accum = accum * 10 + digit;
          end
          return;
        end
        MODE_RELOP: if (c == CH_EQ) begin
          add_piece(KIND_RELOP, held_char, 1'b1, 1'b1, 1'b0);
          mode = MODE_IDLE;
          return;
        end
        default: begin
          open_token(c);
          return;
        end
      endcase
      // The character ends the pending token and starts over from idle.
      close_token();
      held_valid = 1'b0;
      open_token(c);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual kind %0d char %02h",
                 $time, got.kind, got.piece_char);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("piece_char", want.piece_char, got.piece_char);
      compare_field("piece_valid", want.piece_valid, got.piece_valid);
      compare_field("number", want.number, got.number);
      compare_field("number_saturated", want.number_saturated, got.number_saturated);
      compare_field("last_piece", want.last_piece, got.last_piece);
      compare_field("bool_op", want.bool_op, got.bool_op);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block and its channels. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_req_type = 1'b0;
  logic [7:0]           in_char     = 8'h00;
  logic                 out_stall   = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [3:0]           out_kind;
  logic [7:0]           out_piece_char;
  logic                 out_piece_valid;
  logic [OUT_NUM_W-1:0] out_number;
  logic                 out_number_saturated;
  logic                 out_last_piece;
  logic                 out_bool_op;

  lexer_scoreboard sb;
  int  words_sent    = 0;
  int  burst_left    = 0;
  int  cycle_count   = 0;
  bit  hold_request  = 1'b0;

  // Raw material for random source text.
  string name_words[] = '{"and", "or", "not", "a", "an", "o", "n", "no", "andx",
                          "nota", "or1", "AND", "Not", "ord"};
  string symbol_chars = ";,:.+-*/%(){}[]";
  string relop_first  = "=<>!";
  string noise_chars  = "=<>!;:,.+-*/%()[]{}aZ7";

  line_aware_char_lexer_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_char              (in_char),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_piece_char       (out_piece_char),
    .out_piece_valid      (out_piece_valid),
    .out_number           (out_number),
    .out_number_saturated (out_number_saturated),
    .out_last_piece       (out_last_piece),
    .out_bool_op          (out_bool_op)
  );

  always #HALF_PERIOD clk = ~clk;

  // Watchdog: end the run if the traffic never settles.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("line_aware_char_lexer_unit regression: fail");
      $finish;
    end
  end

  // Monitor both channels on the pre-edge values. Note the input word first,
  // so a prediction is always in place before any result it causes.
  always @(posedge clk) begin
    res_t got;
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) sb.note_word(in_req_type, in_char);
      if (out_valid === 1'b1 && !out_stall) begin
        got                  = '0;
        got.kind             = kind_t'(out_kind);
        got.piece_char       = out_piece_char;
        got.piece_valid      = out_piece_valid;
        got.number           = out_number;
        got.number_saturated = out_number_saturated;
        got.last_piece       = out_last_piece;
        got.bool_op          = out_bool_op;
        sb.check_result(got);
      end
    end
  end

  // Receiver: switch between stall styles every so often; on request, hold
  // off for a long stretch so the block backs up and stalls its input.
  initial begin : receiver
    int style;
    int style_left;
    int hold_left;
    style      = STALL_NONE;
    style_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(STALL_NONE, STALL_BEAT);
          style_left = $urandom_range(10, 150);
        end
        style_left--;
        case (style)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= (style_left % 3 == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks.
  // --------------------------------------------------------------------------

  // Drop valid and idle for a number of cycles.
  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted piece has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  // Offer one word and hold it until taken. Bursts of random length, with
  // random gaps between them; some bursts run long with no idling at all.
  task automatic send_word(bit eoi, logic [7:0] c);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      pause_sender($urandom_range(1, 8));
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_req_type <= eoi;
    in_char     <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    words_sent++;
  endtask

  task automatic send_char(logic [7:0] c);
    send_word(1'b0, c);
  endtask

  // End-of-input marker; the character byte is don't-care, so randomize it.
  task automatic send_end();
    send_word(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  function automatic logic [7:0] random_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  function automatic logic [7:0] random_digit();
    return 8'($urandom_range("0", "9"));
  endfunction

  // Whitespace other than LF, space weighted up.
  task automatic send_blanks(int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    repeat (n) begin
      case ($urandom_range(0, 6))
        0: send_char(CH_TAB);
        1: send_char(CH_VT);
        2: send_char(CH_FF);
        3: send_char(CH_CR);
        default: send_char(CH_SPACE);
      endcase
    end
  endtask

  // Keywords, keyword prefixes and lookalikes, or a random name.
  task automatic send_name();
    int len;
    if ($urandom_range(0, 2) == 0) begin
      send_text(name_words[$urandom_range(0, name_words.size() - 1)]);
      return;
    end
    len = $urandom_range(1, 7);
    send_char(random_letter());
    for (int i = 1; i < len; i++) begin
      send_char(($urandom_range(0, 3) == 0) ? random_digit() : random_letter());
    end
  endtask

  // Mostly short integers; some long enough to clamp, some right at the edge.
  task automatic send_number();
    int len;
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) send_text("2147483647");
      else send_text("2147483648");
      return;
    end
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 5);
    repeat (len) send_char(random_digit());
  endtask

  // Quoted string of arbitrary bytes, LF and high bytes included. Now and
  // then leave it open and close the input instead.
  task automatic send_string_token(output bit ended);
    int         len;
    logic [7:0] c;
    ended = 1'b0;
    len   = $urandom_range(0, 6);
    send_char(CH_QUOTE);
    repeat (len) begin
      do begin
        c = ($urandom_range(0, 7) == 0) ? CH_LF : 8'($urandom_range(0, 255));
      end while (c == CH_QUOTE);
      send_char(c);
    end
    if ($urandom_range(0, 15) == 0) begin
      send_end();
      ended = 1'b1;
    end else begin
      send_char(CH_QUOTE);
    end
  endtask

  // Relational pair, or a lone first character left to become a symbol.
  task automatic send_relop();
    send_char(relop_first[$urandom_range(0, 3)]);
    if ($urandom_range(0, 3) != 0) send_char(CH_EQ);
  endtask

  task automatic random_token(output bit ended);
    ended = 1'b0;
    case ($urandom_range(0, 6))
      0, 1: send_name();
      2:    send_number();
      3:    send_string_token(ended);
      4:    send_char(symbol_chars[$urandom_range(0, symbol_chars.len() - 1)]);
      5:    send_relop();
      default: send_char(noise_chars[$urandom_range(0, noise_chars.len() - 1)]);
    endcase
  endtask

  // One source line: optional indent, tokens with mostly blank separators
  // (sometimes jammed together), then LF or, now and then, end of input.
  task automatic random_line();
    int n_tokens;
    bit ended;
    if ($urandom_range(0, 2) == 0) send_blanks(1, 4);
    n_tokens = $urandom_range(0, 6);
    for (int i = 0; i < n_tokens; i++) begin
      if (i > 0 && $urandom_range(0, 7) != 0) send_blanks(1, 2);
      random_token(ended);
      if (ended) return;
    end
    if ($urandom_range(0, 11) == 0) send_end();
    else send_char(CH_LF);
  endtask

  // Short directed opening.
  task automatic run_directed();
    // Indent of space and tab cut off by LF: indent pieces, then eol.
    send_char(CH_SPACE);
    send_char(CH_TAB);
    send_char(CH_LF);
    // Keyword name running straight into a relational pair.
    send_text("or==");
    // Integer closed by a symbol.
    send_text("12;");
    // String holding the lowest byte, LF and the highest byte.
    send_char(CH_QUOTE);
    send_char(8'h00);
    send_char(CH_LF);
    send_char(8'hFF);
    send_char(CH_QUOTE);
    // Empty string.
    send_char(CH_QUOTE);
    send_char(CH_QUOTE);
    // Lone relop character flushed by end of input.
    send_char("<");
    send_end();
    // Unterminated string flushed by end of input.
    send_char(CH_QUOTE);
    send_char("x");
    send_end();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] bad_char;
    int         next_hold;
    bit         mid_drain_done;
    sb             = new();
    next_hold      = 400;
    mid_drain_done = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    wait_for_results();

    while (words_sent < ITEM_TARGET) begin
      // Long receiver hold-off while the sender keeps offering words.
      if (words_sent >= next_hold) begin
        hold_request = 1'b1;
        next_hold   += HOLD_SPACING;
      end
      // Hold the sender once until the result side has caught up.
      if (!mid_drain_done && words_sent >= ITEM_TARGET / 2) begin
        wait_for_results();
        mid_drain_done = 1'b1;
      end
      random_line();
    end

    // Close the input, then an unknown character: error, and the block goes
    // quiet until reset, so nothing may follow it.
    send_end();
    do bad_char = 8'($urandom_range(0, 255)); while (sb.is_known(bad_char));
    send_char(bad_char);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("line_aware_char_lexer_unit regression: pass");
    end else begin
      $display("line_aware_char_lexer_unit regression: fail");
    end
    $finish;
  end

endmodule
